@@ src/oldd_pkg.sv @@
// ----------------------------------------------------------------------------
// oldd_pkg
// Shared types and constants for the ordered list block: word layouts,
// operation codes and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package oldd_pkg;

    localparam int C_CAPACITY = 32;

    localparam logic [1:0] OP_INS_FRONT = 2'd0;
    localparam logic [1:0] OP_INS_BACK  = 2'd1;
    localparam logic [1:0] OP_DELETE    = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] item_value;
        logic [7:0]         position;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] entry_value;
        logic               list_empty;
        logic               insert_dropped;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic load_in;
        logic do_insert;
        logic del_start;
        logic del_rd;
        logic del_wr;
        logic del_done;
        logic dump_start;
        logic dump_run;
    } t_cmd;

    typedef struct packed {
        logic is_insert;
        logic del_ok;
        logic del_more;
        logic dump_done;
    } t_sts;

endpackage

@@ src/oldd_dpath.sv @@
// ----------------------------------------------------------------------------
// oldd_dpath
// List storage as a ring in a single-port-write, registered-read memory,
// with head pointer, fill count, delete compaction and the dump pipeline.
// ----------------------------------------------------------------------------
module oldd_dpath #(
    parameter int CAPACITY = oldd_pkg::C_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  oldd_pkg::t_cmd      i_cmd,
    output oldd_pkg::t_sts      o_sts,
    input  oldd_pkg::t_in_word  i_word,
    output oldd_pkg::t_out_word o_word,
    output logic                o_valid,
    input  logic                i_ready
);
    import oldd_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0]        r_mem [CAPACITY];
    logic [AW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic [1:0]         r_op;
    logic signed [31:0] r_val;
    logic [7:0]         r_pos;
    logic               r_dropped;
    logic               r_rd_vld;
    logic               r_rd_last;
    logic               r_rd_empty;
    logic [31:0]        r_rd_data;
    t_out_word          r_out;
    logic               r_out_vld;

    logic          full;
    logic [CW-1:0] n_items;
    logic [CW:0]   idx_p1;
    logic          issued_all;
    logic          take;
    logic          rd_dump;
    logic          rd_en;
    logic [CW-1:0] lsel;
    logic [CW:0]   sum;
    logic [CW:0]   phys;
    logic [AW-1:0] addr;
    logic [AW-1:0] head_m1;
    logic          ins_ok;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    always_comb begin
        full       = (r_count == CW'(CAPACITY));
        n_items    = (r_count == '0) ? CW'(1) : r_count;
        idx_p1     = (CW+1)'(r_idx) + (CW+1)'(1);
        issued_all = (r_idx == n_items);
        take       = r_rd_vld && (!r_out_vld || i_ready);
        rd_dump    = i_cmd.dump_run && !issued_all && (!r_rd_vld || take);
        rd_en      = rd_dump || i_cmd.del_rd;

        if (i_cmd.do_insert) begin
            lsel = r_count;
        end else if (i_cmd.del_rd) begin
            lsel = idx_p1[CW-1:0];
        end else begin
            lsel = r_idx;
        end
        sum  = (CW+1)'(r_head) + (CW+1)'(lsel);
        phys = (sum >= (CW+1)'(CAPACITY)) ? sum - (CW+1)'(CAPACITY) : sum;
        addr = phys[AW-1:0];

        head_m1 = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);
        ins_ok  = i_cmd.do_insert && !full;
        wr_en   = ins_ok || i_cmd.del_wr;
        wr_addr = (ins_ok && r_op == OP_INS_FRONT) ? head_m1 : addr;
        wr_data = i_cmd.del_wr ? r_rd_data : r_val;

        o_sts.is_insert = (r_op == OP_INS_FRONT) || (r_op == OP_INS_BACK);
        o_sts.del_ok    = (r_op == OP_DELETE) && (r_pos < 8'(r_count));
        o_sts.del_more  = (idx_p1 < (CW+1)'(r_count));
        o_sts.dump_done = issued_all && !r_rd_vld && !r_out_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (ins_ok) begin
                r_count <= r_count + CW'(1);
                if (r_op == OP_INS_FRONT) begin
                    r_head <= head_m1;
                end
            end
            if (i_cmd.del_done) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.del_start) begin
                r_idx <= CW'(r_pos);
            end else if (i_cmd.dump_start) begin
                r_idx <= '0;
            end else if (i_cmd.del_wr || rd_dump) begin
                r_idx <= idx_p1[CW-1:0];
            end
            if (rd_dump) begin
                r_rd_vld <= 1'b1;
            end else if (take) begin
                r_rd_vld <= 1'b0;
            end
            if (take) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op      <= i_word.operation;
            r_val     <= i_word.item_value;
            r_pos     <= i_word.position;
            r_dropped <= 1'b0;
        end else if (i_cmd.do_insert && full) begin
            r_dropped <= 1'b1;
        end
        if (rd_dump) begin
            r_rd_last  <= (idx_p1 == (CW+1)'(n_items));
            r_rd_empty <= (r_count == '0);
        end
        if (take) begin
            r_out.entry_value    <= r_rd_empty ? '0 : r_rd_data;
            r_out.list_empty     <= r_rd_empty;
            r_out.insert_dropped <= r_dropped;
            r_out.last           <= r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    assign o_word  = r_out;
    assign o_valid = r_out_vld;

endmodule

@@ src/oldd_ctrl.sv @@
// ----------------------------------------------------------------------------
// oldd_ctrl
// Sequencer for one operation: capture, insert or delete compaction,
// then the full dump of the list.
// ----------------------------------------------------------------------------
module oldd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  oldd_pkg::t_sts i_sts,
    output oldd_pkg::t_cmd o_cmd
);
    import oldd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DEL_CHK,
        S_DEL_RD,
        S_DEL_WR,
        S_DUMP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_insert) begin
                    o_cmd.do_insert  = 1'b1;
                    o_cmd.dump_start = 1'b1;
                    n_state          = S_DUMP;
                end else if (i_sts.del_ok) begin
                    o_cmd.del_start = 1'b1;
                    n_state         = S_DEL_CHK;
                end else begin
                    o_cmd.dump_start = 1'b1;
                    n_state          = S_DUMP;
                end
            end
            S_DEL_CHK: begin
                if (i_sts.del_more) begin
                    n_state = S_DEL_RD;
                end else begin
                    o_cmd.del_done   = 1'b1;
                    o_cmd.dump_start = 1'b1;
                    n_state          = S_DUMP;
                end
            end
            S_DEL_RD: begin
                o_cmd.del_rd = 1'b1;
                n_state      = S_DEL_WR;
            end
            S_DEL_WR: begin
                o_cmd.del_wr = 1'b1;
                n_state      = S_DEL_CHK;
            end
            S_DUMP: begin
                o_cmd.dump_run = 1'b1;
                if (i_sts.dump_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

@@ src/ordered_list_insert_delete_dump.sv @@
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_dump
// Bounded ordered list of signed values: insert at front or back, delete
// at an index, and stream the whole list out after every operation.
//
//   channel  valid    ready    word
//   input    i_valid  o_ready  i_word  (operation, item_value, position)
//   output   o_valid  i_ready  o_word  (entry_value, list_empty,
//                                       insert_dropped, last)
//
// One operation at a time, and reset empties the list. An insert goes
// straight to the dump; a delete at index p of n entries first shifts the
// n-1-p entries behind p, each shift being one memory read and one write.
// The dump gives max(n,1) words, one a cycle while the output is ready,
// from the registered memory read port. Output stalls hold the dump in place.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_dump #(
    parameter int CAPACITY = oldd_pkg::C_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  oldd_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output oldd_pkg::t_out_word o_word
);
    import oldd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    oldd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    oldd_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_word  (i_word),
        .o_word  (o_word),
        .o_valid (o_valid),
        .i_ready (i_ready)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input taken while dump still pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second word accepted before dump");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.list_empty) |-> (o_word.last && o_word.entry_value == 0))
        else $error("empty list word malformed");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered list block. Operations are sent on the
// input channel and the model below replays each accepted word on a queue of
// values, so it can predict the full dump that must follow. Every dump word
// is compared field by field in order. The tests cover directed corner cases,
// overflow of a full list, random grow and shrink phases, a long output
// stall that backs up the input, and a closing stretch with no idling.
// ----------------------------------------------------------------------------
module tb_top;
    import oldd_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         MAX_SHOWN = 10;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_ready = 1'b0;
    t_in_word  i_word  = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_word o_word;

    logic signed [31:0] list_model[$];
    t_out_word          expected_dump[$];
    int                 error_count  = 0;
    bit                 idle_on      = 1'b1;
    bit                 long_hold_req = 1'b0;
    int                 hold_left    = 0;
    int                 stall_left   = 0;

    ordered_list_insert_delete_dump u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #(12 * 3_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void apply_list_op(input t_in_word w);
        logic      dropped;
        t_out_word ow;
        int        n;
        dropped = 1'b0;
        case (w.operation)
            OP_INS_FRONT, OP_INS_BACK: begin
                if (list_model.size() >= C_CAPACITY) begin
                    dropped = 1'b1;
                end else if (w.operation == OP_INS_FRONT) begin
                    list_model.push_front(w.item_value);
                end else begin
                    list_model.push_back(w.item_value);
                end
            end
            OP_DELETE: begin
                if (int'(w.position) < list_model.size())
                    list_model.delete(int'(w.position));
            end
            default: ;
        endcase
        n = list_model.size();
        if (n == 0) begin
            ow.entry_value    = '0;
            ow.list_empty     = 1'b1;
            ow.insert_dropped = dropped;
            ow.last           = 1'b1;
            expected_dump.push_back(ow);
        end else begin
            for (int i = 0; i < n; i++) begin
                ow.entry_value    = list_model[i];
                ow.list_empty     = 1'b0;
                ow.insert_dropped = dropped;
                ow.last           = (i == n - 1);
                expected_dump.push_back(ow);
            end
        end
    endfunction

    function automatic t_in_word make_word(input logic [1:0] op,
                                           input logic [31:0] val,
                                           input logic [7:0] pos);
        t_in_word w;
        w.operation  = op;
        w.item_value = val;
        w.position   = pos;
        return w;
    endfunction

    // insert weight in percent; deletes mostly hit a live entry
    function automatic t_in_word random_list_op(input int ins_weight);
        int         r;
        logic [7:0] pos;
        logic [1:0] op;
        r   = $urandom_range(0, 99);
        pos = 8'($urandom_range(0, 255));
        if (r < ins_weight) begin
            op = $urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT;
        end else if (r < 97) begin
            op = OP_DELETE;
            if (list_model.size() > 0 && $urandom_range(0, 99) < 85)
                pos = 8'($urandom_range(0, list_model.size() - 1));
        end else begin
            op = OP_UNUSED;
        end
        return make_word(op, $urandom, pos);
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        apply_list_op(w);
    endtask

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic check_dump_word(input t_out_word got);
        t_out_word want;
        if (expected_dump.size() == 0) begin
            report_error($sformatf("unexpected word: value %0d empty %0b dropped %0b last %0b",
                                   got.entry_value, got.list_empty,
                                   got.insert_dropped, got.last));
            return;
        end
        want = expected_dump.pop_front();
        if (got.entry_value !== want.entry_value)
            report_error($sformatf("entry_value: exp %0d got %0d",
                                   want.entry_value, got.entry_value));
        if (got.list_empty !== want.list_empty)
            report_error($sformatf("list_empty: exp %0b got %0b",
                                   want.list_empty, got.list_empty));
        if (got.insert_dropped !== want.insert_dropped)
            report_error($sformatf("insert_dropped: exp %0b got %0b",
                                   want.insert_dropped, got.insert_dropped));
        if (got.last !== want.last)
            report_error($sformatf("last: exp %0b got %0b", want.last, got.last));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                check_dump_word(o_word);
            if (long_hold_req) begin
                hold_left     = 300;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        send_word(make_word(OP_DELETE,    32'h0000_0000, 8'd0));
        send_word(make_word(OP_UNUSED,    32'h0000_0005, 8'd0));
        send_word(make_word(OP_INS_FRONT, 32'h7FFF_FFFF, 8'd0));
        send_word(make_word(OP_INS_BACK,  32'h8000_0000, 8'd0));
        send_word(make_word(OP_INS_FRONT, 32'hFFFF_FFFF, 8'd0));
        send_word(make_word(OP_INS_BACK,  32'h0000_0000, 8'd0));
        send_word(make_word(OP_INS_FRONT, 32'h5555_5555, 8'hFF));
        send_word(make_word(OP_DELETE,    32'hFFFF_FFFF, 8'hFF));
        send_word(make_word(OP_DELETE,    32'h0000_0000, 8'd5));
        send_word(make_word(OP_DELETE,    32'h0000_0000, 8'd2));
        send_word(make_word(OP_DELETE,    32'h0000_0000, 8'd3));
        send_word(make_word(OP_DELETE,    32'h0000_0000, 8'd0));
        send_word(make_word(OP_UNUSED,    32'hAAAA_AAAA, 8'hAA));
        send_word(make_word(OP_INS_BACK,  32'h2AAA_AAAA, 8'h55));
        send_word(make_word(OP_DELETE,    32'h0000_0000, 8'd0));
        send_word(make_word(OP_DELETE,    32'h0000_0000, 8'd0));
        send_word(make_word(OP_DELETE,    32'h0000_0000, 8'd0));
        send_word(make_word(OP_DELETE,    32'h0000_0000, 8'd0));
        send_word(make_word(OP_INS_BACK,  32'h0000_0001, 8'd0));
        send_word(make_word(OP_DELETE,    32'h0000_0000, 8'd1));
    endtask

    task automatic test_full_list();
        while (list_model.size() < C_CAPACITY)
            send_word(make_word($urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT,
                                $urandom, 8'($urandom_range(0, 255))));
        send_word(make_word(OP_INS_FRONT, $urandom, 8'd0));
        send_word(make_word(OP_INS_BACK,  $urandom, 8'd0));
        send_word(make_word(OP_DELETE,    32'h0, 8'(C_CAPACITY - 1)));
        send_word(make_word(OP_DELETE,    32'h0, 8'(C_CAPACITY - 1)));
        send_word(make_word(OP_INS_BACK,  $urandom, 8'd0));
        send_word(make_word(OP_DELETE,    32'h0, 8'd0));
        send_word(make_word(OP_INS_FRONT, $urandom, 8'd0));
        send_word(make_word(OP_INS_FRONT, $urandom, 8'd0));
        send_word(make_word(OP_INS_BACK,  $urandom, 8'd0));
    endtask

    task automatic test_random_ops();
        int weights[6] = '{65, 35, 55, 80, 25, 50};
        foreach (weights[k])
            repeat (40) send_word(random_list_op(weights[k]));
    endtask

    task automatic test_output_hold();
        long_hold_req = 1'b1;
        repeat (20) send_word(random_list_op(60));
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        repeat (40) send_word(random_list_op(50));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_list();
        test_random_ops();
        test_output_hold();
        test_no_idle();
        i_valid <= 1'b0;
        while (expected_dump.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (error_count == 0 && expected_dump.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/oldd_pkg.sv
src/oldd_dpath.sv
src/oldd_ctrl.sv
src/ordered_list_insert_delete_dump.sv
dv/tb_top.sv
